@@ rtl/gsm_pkg.sv @@
// Shared types and constants of the golden-section minimizer.
`timescale 1ns / 1ps

package gsm_pkg;

  localparam int unsigned MAX_ITER = 64;
  localparam int unsigned ITER_W = 7;
  localparam int unsigned ACC_W = 31;

  localparam logic [31:0] GOLD_Q32 = 32'd2654435769;
  localparam logic signed [32:0] F_COEF = 33'sd327680;

  typedef struct packed {
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } gsm_in_t;

  typedef struct packed {
    logic signed [31:0] minimum_point;
    logic [ITER_W-1:0] iterations;
    logic hit_limit;
  } gsm_out_t;

  typedef enum logic {
    MUL_STEP = 1'b0,
    MUL_FVAL = 1'b1
  } mul_op_t;

  typedef struct packed {
    logic start;
    mul_op_t op;
    logic [31:0] arg;
  } mul_req_t;

endpackage

@@ rtl/gsm_mul.sv @@
// Shared multiplier of the minimizer with operand selection and a registered product.
`timescale 1ns / 1ps

module gsm_mul (
  input  logic              clk,
  input  gsm_pkg::mul_req_t req,
  output logic [63:0]       prod
);

  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] full;

  always_comb begin
    unique case (req.op)
      gsm_pkg::MUL_STEP: begin
        opa = {1'b0, req.arg};
        opb = {1'b0, gsm_pkg::GOLD_Q32};
      end
      gsm_pkg::MUL_FVAL: begin
        opa = {req.arg[31], req.arg};
        opb = $signed({req.arg[31], req.arg}) - gsm_pkg::F_COEF;
      end
    endcase
  end

  assign full = opa * opb;

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= full[63:0];
    end
  end

endmodule

@@ rtl/golden_section_minimizer_unit.sv @@
// Top level of the golden-section minimizer with its sequencer and datapath.
`timescale 1ns / 1ps

// The block finds the minimum of f(x) = x*x - 5*x on one interval per transfer.
// An input transfer on in_valid/in_ready carries lower_bound and upper_bound in
// signed Q16.16. The block takes a new interval only while its sequencer is idle.
// One result transfer on out_valid/out_ready follows each input transfer and
// carries the midpoint of the final interval, the number of reductions and a
// flag that the iteration limit stopped the search.
// The stop width is written through accuracy_we and accuracy_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Each reduction runs through a compare, a product for the golden step, a
// point update, and the product of f(x) and its store, with both products on
// the single shared multiplier. A new interval can be taken as soon as the
// result sits in the output register, even while the receiver stalls; if the
// receiver still holds the previous result, the sequencer waits before loading
// the next one. Reset clears the sequencer and the output valid and sets the
// stop width to 1.
module golden_section_minimizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gsm_pkg::gsm_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gsm_pkg::gsm_out_t             out_data,
  input  logic                          accuracy_we,
  input  logic [gsm_pkg::ACC_W-1:0]     accuracy_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_STEP   = 7'b0000010,
    S_POINT  = 7'b0000100,
    S_FEVAL  = 7'b0001000,
    S_FSTORE = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [gsm_pkg::ACC_W-1:0]  accuracy;
  logic signed [31:0]         a;
  logic signed [31:0]         b;
  logic signed [31:0]         x1;
  logic signed [31:0]         x2;
  logic signed [63:0]         f1;
  logic signed [63:0]         f2;
  logic [gsm_pkg::ITER_W-1:0] iter;
  logic                       hit;
  logic                       init;
  logic                       sel;
  logic                       step_neg;

  logic signed [32:0] diff;
  logic [32:0]        diff_neg;
  logic [31:0]        diff_mag;
  logic               width_ok;
  logic signed [32:0] sum;
  logic [31:0]        step_mag;
  logic [31:0]        step_val;
  logic [63:0]        prod;
  logic               out_load;

  gsm_pkg::mul_req_t  mul_req;

  assign diff     = {b[31], b} - {a[31], a};
  assign diff_neg = -diff;
  assign diff_mag = diff[32] ? diff_neg[31:0] : diff[31:0];
  assign width_ok = diff_mag <= {1'b0, accuracy};
  assign sum      = {a[31], a} + {b[31], b};
  assign step_mag = prod[63:32];
  assign step_val = step_neg ? (32'd0 - step_mag) : step_mag;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    mul_req.start = (state == S_STEP) || (state == S_FEVAL);
    mul_req.op    = (state == S_STEP) ? gsm_pkg::MUL_STEP : gsm_pkg::MUL_FVAL;
    if (state == S_STEP) begin
      mul_req.arg = diff_mag;
    end else begin
      mul_req.arg = sel ? x2 : x1;
    end
  end

  gsm_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy <= gsm_pkg::ACC_W'(1);
    end else if (accuracy_we) begin
      accuracy <= accuracy_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a     <= in_data.lower_bound;
            b     <= in_data.upper_bound;
            iter  <= '0;
            hit   <= 1'b0;
            init  <= 1'b1;
            sel   <= 1'b0;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          step_neg <= diff[32];
          state    <= S_POINT;
        end
        S_POINT: begin
          if (init) begin
            x1 <= b - step_val;
            x2 <= a + step_val;
          end else if (sel) begin
            x2 <= a + step_val;
          end else begin
            x1 <= b - step_val;
          end
          state <= S_FEVAL;
        end
        S_FEVAL: begin
          state <= S_FSTORE;
        end
        S_FSTORE: begin
          if (sel) begin
            f2 <= prod;
          end else begin
            f1 <= prod;
          end
          if (init && !sel) begin
            sel   <= 1'b1;
            state <= S_FEVAL;
          end else begin
            init  <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (width_ok) begin
            state <= S_OUT;
          end else if (iter >= gsm_pkg::ITER_W'(gsm_pkg::MAX_ITER)) begin
            hit   <= 1'b1;
            state <= S_OUT;
          end else begin
            if (f1 >= f2) begin
              f1  <= f2;
              a   <= x1;
              x1  <= x2;
              sel <= 1'b1;
            end else begin
              f2  <= f1;
              b   <= x2;
              x2  <= x1;
              sel <= 1'b0;
            end
            iter  <= iter + 1'b1;
            state <= S_STEP;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data.minimum_point <= sum[32:1];
            out_data.iterations    <= iter;
            out_data.hit_limit     <= hit;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= gsm_pkg::ITER_W'(gsm_pkg::MAX_ITER))
    else $error("iteration count exceeds its limit");

  a_hit_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit_limit) |->
      (out_data.iterations == gsm_pkg::ITER_W'(gsm_pkg::MAX_ITER)))
    else $error("limit flag set below the iteration limit");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_STEP))
    else $error("accepted interval did not start a step");

  a_point_after_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_POINT) |-> ($past(state) == S_STEP))
    else $error("point update without a fresh step product");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the golden-section minimizer unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 166;
  localparam int unsigned NUM_DIRECTED = 23;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic [gsm_pkg::ACC_W-1:0] ACC_MAX = 31'h7FFF_FFFF;

  typedef struct {
    logic [gsm_pkg::ACC_W-1:0] acc;
    gsm_pkg::gsm_in_t iv;
    bit typed;
    gsm_pkg::gsm_out_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  gsm_pkg::gsm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gsm_pkg::gsm_out_t out_data;
  logic accuracy_we = 1'b0;
  logic [gsm_pkg::ACC_W-1:0] accuracy_data = '0;

  gsm_pkg::gsm_out_t pending_results[$];
  logic [gsm_pkg::ACC_W-1:0] accuracy_now = 31'd1;
  bit holding = 1'b0;
  bit steady_flow = 1'b0;
  int unsigned mismatches = 0;
  int unsigned intervals_sent = 0;
  int unsigned results_seen = 0;
  int unsigned limit_stops = 0;
  int unsigned accuracy_writes = 0;
  int unsigned idle_cycles = 0;

  // Equal bounds and intervals already within the stop width have results
  // that need no search, so those rows carry their expected result.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{31'd1, '{32'sd0, 32'sd0}, 1'b1, '{32'sd0, 7'd0, 1'b0}},
    '{31'd1, '{32'sd0, 32'sd1}, 1'b1, '{32'sd0, 7'd0, 1'b0}},
    '{31'd1, '{-32'sd1, 32'sd0}, 1'b1, '{-32'sd1, 7'd0, 1'b0}},
    '{31'd1, '{P_MAX, P_MAX}, 1'b1, '{P_MAX, 7'd0, 1'b0}},
    '{31'd1, '{P_MIN, P_MIN}, 1'b1, '{P_MIN, 7'd0, 1'b0}},
    '{31'd1, '{-32'sd327680, 32'sd655360}, 1'b0, '0},
    '{31'd1, '{P_MIN, P_MAX}, 1'b0, '0},
    '{31'd1, '{P_MAX, P_MIN}, 1'b0, '0},
    '{31'd1, '{32'sd655360, -32'sd327680}, 1'b0, '0},
    '{31'd1, '{32'sd0, 32'sd327680}, 1'b0, '0},
    '{31'd1, '{32'sd163840, 32'sd163843}, 1'b0, '0},
    '{31'd0, '{P_MIN, P_MAX}, 1'b0, '0},
    '{31'd0, '{32'sd0, 32'sd1}, 1'b0, '0},
    '{31'd0, '{32'sd7, 32'sd7}, 1'b1, '{32'sd7, 7'd0, 1'b0}},
    '{31'd0, '{-32'sd196608, 32'sd524288}, 1'b0, '0},
    '{31'd0, '{32'sd1, -32'sd1}, 1'b0, '0},
    '{ACC_MAX, '{32'sd0, 32'sd100}, 1'b1, '{32'sd50, 7'd0, 1'b0}},
    '{ACC_MAX, '{-32'sd1, 32'sh7FFF_FFFE}, 1'b1, '{32'sh3FFF_FFFE, 7'd0, 1'b0}},
    '{ACC_MAX, '{P_MIN, 32'sd0}, 1'b0, '0},
    '{ACC_MAX, '{P_MIN, P_MAX}, 1'b0, '0},
    '{31'd65536, '{-32'sd6553600, 32'sd6553600}, 1'b0, '0},
    '{31'd65536, '{P_MAX, P_MIN}, 1'b0, '0},
    '{31'd16, '{32'sd163790, 32'sd163890}, 1'b0, '0}
  };

  golden_section_minimizer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .accuracy_we(accuracy_we),
    .accuracy_data(accuracy_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint golden_step(longint d);
    logic [63:0] mag;
    logic [63:0] low_prod;
    logic [63:0] r;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    low_prod = {32'd0, mag[31:0]} * {32'd0, gsm_pkg::GOLD_Q32};
    r = {32'd0, mag[63:32]} * {32'd0, gsm_pkg::GOLD_Q32} + (low_prod >> 32);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint parabola(longint x);
    return x * x - x * longint'(gsm_pkg::F_COEF);
  endfunction

  function automatic gsm_pkg::gsm_out_t predict_minimum(gsm_pkg::gsm_in_t iv,
                                                        logic [gsm_pkg::ACC_W-1:0] acc);
    longint a;
    longint b;
    longint x1;
    longint x2;
    longint f1;
    longint f2;
    longint mid;
    int unsigned n;
    bit hit;
    gsm_pkg::gsm_out_t r;
    a = longint'(iv.lower_bound);
    b = longint'(iv.upper_bound);
    x1 = b - golden_step(b - a);
    x2 = a + golden_step(b - a);
    f1 = parabola(x1);
    f2 = parabola(x2);
    n = 0;
    hit = 1'b0;
    while (((b >= a) ? b - a : a - b) > longint'(acc)) begin
      if (n >= gsm_pkg::MAX_ITER) begin
        hit = 1'b1;
        break;
      end
      if (f1 >= f2) begin
        f1 = f2;
        a = x1;
        x1 = x2;
        x2 = a + golden_step(b - a);
        f2 = parabola(x2);
      end else begin
        f2 = f1;
        b = x2;
        x2 = x1;
        x1 = b - golden_step(b - a);
        f1 = parabola(x1);
      end
      n++;
    end
    mid = (a + b) >>> 1;
    r.minimum_point = mid[31:0];
    r.iterations = n[gsm_pkg::ITER_W-1:0];
    r.hit_limit = hit;
    return r;
  endfunction

  function automatic logic signed [31:0] boundary_value();
    case ($urandom_range(0, 5))
      0: return P_MIN;
      1: return P_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Two in five intervals are centred near the minimum at 2.5 with widths of every scale.
  function automatic gsm_pkg::gsm_in_t random_interval();
    gsm_pkg::gsm_in_t iv;
    int center;
    int span;
    int unsigned kind;
    logic signed [31:0] t;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      center = 163840 + int'($urandom_range(0, 1 << 22)) - (1 << 21);
      span = int'($urandom_range(0, 1 << $urandom_range(0, 24)));
      iv.lower_bound = center - span / 2;
      iv.upper_bound = iv.lower_bound + span;
    end else if (kind < 65) begin
      iv.lower_bound = $urandom();
      iv.upper_bound = $urandom();
    end else if (kind < 85) begin
      iv.lower_bound = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      iv.upper_bound = iv.lower_bound + int'($urandom_range(0, 1 << 25));
    end else if (kind < 92) begin
      iv.lower_bound = $urandom();
      iv.upper_bound = iv.lower_bound;
    end else begin
      iv.lower_bound = boundary_value();
      iv.upper_bound = boundary_value();
    end
    if ($urandom_range(0, 9) == 0) begin
      t = iv.lower_bound;
      iv.lower_bound = iv.upper_bound;
      iv.upper_bound = t;
    end
    return iv;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic drop_valid();
    if (holding) begin
      in_valid <= 1'b0;
      holding = 1'b0;
    end
  endtask

  task automatic settle_block();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_accuracy(logic [gsm_pkg::ACC_W-1:0] value);
    settle_block();
    @(posedge clk);
    accuracy_we <= 1'b1;
    accuracy_data <= value;
    @(posedge clk);
    accuracy_we <= 1'b0;
    accuracy_now = value;
    accuracy_writes++;
  endtask

  task automatic send_interval(gsm_pkg::gsm_in_t iv, bit typed,
                               gsm_pkg::gsm_out_t typed_result);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= iv;
    holding = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? typed_result : predict_minimum(iv, accuracy_now));
    intervals_sent++;
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : result_side
    int unsigned stall;
    bit late;
    gsm_pkg::gsm_out_t got;
    gsm_pkg::gsm_out_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      late = 1'($urandom_range(0, 1));
      if (stall != 0) begin
        out_ready <= 1'b0;
        if (late) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      results_seen++;
      if (got.hit_limit) limit_stops++;
      if (pending_results.size() == 0) begin
        report($sformatf("result point %0d with no interval pending", got.minimum_point));
      end else begin
        want = pending_results.pop_front();
        if (got.minimum_point !== want.minimum_point) begin
          report($sformatf("minimum_point got %0d want %0d",
                           got.minimum_point, want.minimum_point));
        end
        if (got.iterations !== want.iterations) begin
          report($sformatf("iterations got %0d want %0d", got.iterations, want.iterations));
        end
        if (got.hit_limit !== want.hit_limit) begin
          report($sformatf("hit_limit got %0b want %0b", got.hit_limit, want.hit_limit));
        end
      end
    end
  end

  initial begin : stimulus
    logic [gsm_pkg::ACC_W-1:0] acc;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].acc != accuracy_now) set_accuracy(directed_rows[i].acc);
      send_interval(directed_rows[i].iv, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: acc = 31'd1;
        1: acc = 31'd0;
        2: acc = ACC_MAX;
        3: acc = 31'd65536;
        4: acc = 31'($urandom_range(2, 4096));
        5: acc = 31'd6554;
        6: acc = 31'($urandom() >> 1) >> $urandom_range(0, 30);
        default: acc = 31'd1;
      endcase
      set_accuracy(acc);
      steady_flow = (phase % 3 == 2);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 49) == 0) settle_block();
        send_interval(random_interval(), 1'b0, '0);
      end
    end
    settle_block();
    repeat (400) @(posedge clk);
    $display("Ran %0d intervals (%0d directed) through %0d stop-width writes.",
             intervals_sent, NUM_DIRECTED, accuracy_writes);
    $display("Checked %0d results, %0d of them stopped by the iteration limit, %0d mismatches.",
             results_seen, limit_stops, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ golden_section_minimizer_unit.f @@
rtl/gsm_pkg.sv
rtl/gsm_mul.sv
rtl/golden_section_minimizer_unit.sv
verif/testbench.sv
